>>> rtl/core/vbq_pkg.sv
`default_nettype none

package vbq_pkg;

    // Widths of the fixed fields
    localparam int CountWidth   = 8;
    localparam int VolumeWidth  = 4;
    localparam int PotWidth     = 8;
    localparam int CfgIdxWidth  = 8;
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 16;

    // Number of volume steps and derived limits
    localparam int VolumeLevels = 16;
    localparam logic [VolumeWidth-1:0] VolumeTop = VolumeWidth'(VolumeLevels - 1);
    localparam logic [VolumeWidth-1:0] VolumeReset =
        (VolumeLevels - 1 < 4) ? VolumeWidth'(VolumeLevels - 1) : VolumeWidth'(4);

    // Reset values of the reload registers
    localparam logic [CountWidth-1:0] StableTicksReset = 8'd10;
    localparam logic [CountWidth-1:0] OffTicksReset    = 8'd100;

    // Potentiometer code constants
    localparam logic [PotWidth-1:0] PotFull = 8'hFF;
    localparam int PotStepShift = 4;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] RegStableTicks = 8'd0;
    localparam logic [CfgIdxWidth-1:0] RegOffTicks    = 8'd1;

    // Reload values from the configuration registers
    typedef struct packed {
        logic [CountWidth-1:0] stable_ticks;
        logic [CountWidth-1:0] off_ticks;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic                   power_off;
        logic [PotWidth-1:0]    pot_code;
        logic [VolumeWidth-1:0] volume_level;
        logic                   volume_changed;
    } result_t;

    // Volume index to potentiometer code: index * 16, full scale at the top
    function automatic logic [PotWidth-1:0] pot_for(input logic [VolumeWidth-1:0] idx);
        logic [PotWidth-1:0] code;
        begin
            code = PotWidth'(idx) << PotStepShift;
            if (idx >= VolumeTop)
                code = PotFull;
            return code;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/vbq_cfg_regs.sv
`default_nettype none

module vbq_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vbq_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [vbq_pkg::CountWidth-1:0]  cfg_data,
    output vbq_pkg::cfg_t                       cfg
);
    import vbq_pkg::*;

    logic [CountWidth-1:0] stable_ticks_reg;
    logic [CountWidth-1:0] off_ticks_reg;

    // Writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_ticks_reg <= StableTicksReset;
            off_ticks_reg    <= OffTicksReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegStableTicks: stable_ticks_reg <= cfg_data;
                RegOffTicks:    off_ticks_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg.stable_ticks = stable_ticks_reg;
    assign cfg.off_ticks    = off_ticks_reg;

endmodule

`default_nettype wire

>>> rtl/core/vbq_tick_logic.sv
`default_nettype none

module vbq_tick_logic (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tick,
    input  wire logic          up_level,
    input  wire logic          down_level,
    input  wire vbq_pkg::cfg_t cfg,
    output vbq_pkg::result_t   result
);
    import vbq_pkg::*;

    logic [CountWidth-1:0]  up_cnt_reg,   up_cnt_next;
    logic [CountWidth-1:0]  down_cnt_reg, down_cnt_next;
    logic [CountWidth-1:0]  idle_cnt_reg, idle_cnt_next;
    logic [VolumeWidth-1:0] volume_reg,   volume_next;
    logic                   up_fired;
    logic                   down_fired;
    logic                   off_req;

    // Inactivity counter and power-off request
    always_comb
    begin
        idle_cnt_next = idle_cnt_reg;
        off_req       = 1'b0;
        if (!up_level && !down_level)
        begin
            if (idle_cnt_reg != '0)
                idle_cnt_next = idle_cnt_reg - 1'b1;
            else
                off_req = 1'b1;
        end
        else
        begin
            idle_cnt_next = cfg.off_ticks;
        end
    end

    // Button qualification and volume stepping; an up step masks the down button
    always_comb
    begin
        up_cnt_next   = up_cnt_reg;
        down_cnt_next = down_cnt_reg;
        volume_next   = volume_reg;
        up_fired      = 1'b0;
        down_fired    = 1'b0;

        if (!up_level)
        begin
            if (up_cnt_reg != '0)
                up_cnt_next = up_cnt_reg - 1'b1;
        end
        else if (up_cnt_reg == '0)
        begin
            up_fired    = 1'b1;
            up_cnt_next = cfg.stable_ticks;
            if (volume_reg < VolumeTop)
                volume_next = volume_reg + 1'b1;
        end

        if (!up_fired)
        begin
            if (!down_level)
            begin
                if (down_cnt_reg != '0)
                    down_cnt_next = down_cnt_reg - 1'b1;
            end
            else if (down_cnt_reg == '0)
            begin
                down_fired    = 1'b1;
                down_cnt_next = cfg.stable_ticks;
                if (volume_reg != '0)
                    volume_next = volume_reg - 1'b1;
            end
        end
    end

    // State advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_cnt_reg   <= StableTicksReset;
            down_cnt_reg <= StableTicksReset;
            idle_cnt_reg <= OffTicksReset;
            volume_reg   <= VolumeReset;
        end
        else if (tick)
        begin
            up_cnt_reg   <= up_cnt_next;
            down_cnt_reg <= down_cnt_next;
            idle_cnt_reg <= idle_cnt_next;
            volume_reg   <= volume_next;
        end
    end

    // Result for this tick
    assign result.volume_changed = up_fired | down_fired;
    assign result.volume_level   = volume_next;
    assign result.pot_code       = pot_for(volume_next);
    assign result.power_off      = off_req;

endmodule

`default_nettype wire

>>> rtl/core/volume_button_qualifier.sv
// Debounced up/down volume control.
// Input stream (s_axis): one transfer per sampling tick carrying the two
// button levels. Output stream (m_axis): one transfer per input transfer
// with the step flag, the volume index, its potentiometer code and the
// power-off request.
// Configuration channel: cfg_index 0 writes stable_ticks, 1 writes off_ticks;
// other indexes are ignored. New values apply at the next counter reload.
// A result is offered on m_axis in the cycle after its input transfer.
// Throughput: one tick per cycle while s_axis_tready is high; the button and idle
// counters step on each accepted tick and the result sits in one output register.
// s_axis_tready is high while the output register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and back-pressures
// the input after one result is waiting.
// Reset: counters reload from their reset values (10, 10, 100), volume
// starts at 4, the output register is empty.
`default_nettype none

module volume_button_qualifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [vbq_pkg::InDataWidth-1:0]   s_axis_tdata,  // [0] up_level, [1] down_level
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [vbq_pkg::OutDataWidth-1:0]       m_axis_tdata,  // [0] volume_changed,
                                                                  // [4:1] volume_level,
                                                                  // [12:5] pot_code,
                                                                  // [13] power_off
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vbq_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [vbq_pkg::CountWidth-1:0]    cfg_data
);
    import vbq_pkg::*;

    localparam int ResultWidth = $bits(result_t);

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    in_xfer;

    vbq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    vbq_tick_logic u_tick_logic (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (in_xfer),
        .up_level   (s_axis_tdata[0]),
        .down_level (s_axis_tdata[1]),
        .cfg        (cfg),
        .result     (result)
    );

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataWidth - ResultWidth){1'b0}}, result_reg};

endmodule

`default_nettype wire
